>>> rtl/motor_speed_pid_with_filter_defines.svh
// Assertion macros for the motor speed controller.
`ifndef MOTOR_SPEED_PID_WITH_FILTER_DEFINES_SVH
`define MOTOR_SPEED_PID_WITH_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define MSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define MSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define MSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/msp_pkg.sv
// Shared widths, constants and types of the motor speed controller.
package msp_pkg;

	// Field and state widths
	localparam int COUNT_BITS = 12;
	localparam int SPEED_W    = 24;
	localparam int ERR_W      = 25;
	localparam int DIFF_W     = 26;
	localparam int SUM_W      = 40;
	localparam int GAIN_W     = 16;
	localparam int DUTY_W     = 8;
	localparam int DIR_W      = 2;

	// Shared multiplier and accumulator
	localparam int MUL_W = 33;
	localparam int ACC_W = 64;

	// Configuration port
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RUN    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DIR    = 3'd5;

	// Bridge direction codes
	localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
	localparam logic [DIR_W-1:0] DIR_CW  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_CCW = 2'd2;
	localparam logic [DIR_W-1:0] DIR_BAD = 2'd3;

	// Filter: num = pulses*64000 + 396*filtered + 220, speed = num / 440
	localparam logic [MUL_W-1:0] FILT_PULSE_K = 33'd64000;
	localparam logic [MUL_W-1:0] FILT_KEEP_K  = 33'd396;
	localparam logic signed [ACC_W-1:0] FILT_ROUND = 64'sd220;
	localparam int NUM_W          = 34;
	localparam int FILT_PRE_SHIFT = 3;
	// ceil(2^37 / 55): exact floor division by 55 for operands below 2^31
	localparam logic [MUL_W-1:0] RECIP_55 = 33'd2498890064;
	localparam int RECIP_SHIFT = 37;
	localparam int SPEED_Q_W   = 26;

	// PID scaling
	localparam logic [MUL_W-1:0] P_SCALE = 33'd20;
	localparam logic [MUL_W-1:0] D_SCALE = 33'd400;
	localparam int GP20_W    = 21;
	localparam int GD400_W   = 25;
	localparam int SUM_SPLIT = 20;

	// Duty: drive / 1310720 = (drive >> 18) / 5
	localparam int DUTY_SHIFT = 18;
	localparam int X_W        = 11;
	localparam logic signed [ACC_W-1:0] DUTY_SAT_LEVEL = 64'sd1280 <<< DUTY_SHIFT;
	// ceil(2^18 / 5): exact floor division by 5 for operands below 2^18
	localparam logic [MUL_W-1:0] DIV5_RECIP = 33'd52429;
	localparam int DIV5_SHIFT = 18;

	typedef logic [MUL_W-1:0] mul_op_t;

	typedef struct packed {
		logic en;    // update the accumulator
		logic keep;  // add onto the held accumulator
		logic shl;   // weight the product by 2^SUM_SPLIT
		logic rnd;   // add the filter rounding bias
	} mac_ctl_t;

endpackage

>>> rtl/msp_tick_if.sv
// Request channel carrying the pulse count of one tick.
interface msp_tick_if;
	logic valid;
	logic ready;
	logic [msp_pkg::COUNT_BITS-1:0] pulse_count;

	modport source (output valid, output pulse_count, input ready);
	modport sink (input valid, input pulse_count, output ready);
endinterface

>>> rtl/msp_drive_if.sv
// Result channel carrying duty, bridge mode and speed estimate.
interface msp_drive_if;
	logic valid;
	logic ready;
	logic [msp_pkg::DUTY_W-1:0]  pwm_duty;
	logic [msp_pkg::DIR_W-1:0]   bridge_mode;
	logic [msp_pkg::SPEED_W-1:0] speed_estimate;

	modport source (output valid, output pwm_duty, output bridge_mode, output speed_estimate,
		input ready);
	modport sink (input valid, input pwm_duty, input bridge_mode, input speed_estimate,
		output ready);
endinterface

>>> rtl/msp_mac.sv
// Shared signed multiply-accumulate unit with a registered accumulator.
module msp_mac (
	input  logic                              clk,
	input  msp_pkg::mac_ctl_t                 ctl,
	input  msp_pkg::mul_op_t                  op_a,
	input  msp_pkg::mul_op_t                  op_b,
	output logic signed [msp_pkg::ACC_W-1:0]  acc
);

	logic signed [2*msp_pkg::MUL_W-1:0] prod;
	logic signed [msp_pkg::ACC_W-1:0]   term;
	logic signed [msp_pkg::ACC_W-1:0]   base;
	logic signed [msp_pkg::ACC_W-1:0]   bias;
	logic signed [msp_pkg::ACC_W-1:0]   acc_q;

	// Multiply, weight and sum onto the selected base
	always_comb begin
		prod = $signed(op_a) * $signed(op_b);
		term = $signed(prod[msp_pkg::ACC_W-1:0]);
		if (ctl.shl) begin
			term = term <<< msp_pkg::SUM_SPLIT;
		end
		base = ctl.keep ? acc_q : '0;
		bias = ctl.rnd ? msp_pkg::FILT_ROUND : '0;
	end

	// Hold the accumulator unless enabled
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + term + bias;
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/motor_speed_pid_with_filter.sv
// Motor speed controller: EMA speed filter and PID drive with an APB register port.
// A request steps through FILT_KEEP, RECIP, SPEED, ERR, GD, MP, MD, MIL, MIH, SCALE
// and DUTY; a shared multiplier takes ten products in turn; requests are taken only in IDLE.
// A full output register holds the last step; a new request is taken while one result waits.
// Reset (arst_n low, asynchronous) clears filter, integral and prior error and loads
// register defaults.
`include "motor_speed_pid_with_filter_defines.svh"

module motor_speed_pid_with_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msp_pkg::ADDR_W-1:0]    paddr,
	input  logic [msp_pkg::DATA_W-1:0]    pwdata,
	output logic [msp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	msp_tick_if.sink                      tick,
	msp_drive_if.source                   drive
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
	localparam logic [ST_W-1:0] ST_FILT_KEEP = 4'd1;
	localparam logic [ST_W-1:0] ST_RECIP     = 4'd2;
	localparam logic [ST_W-1:0] ST_SPEED     = 4'd3;
	localparam logic [ST_W-1:0] ST_ERR       = 4'd4;
	localparam logic [ST_W-1:0] ST_GD        = 4'd5;
	localparam logic [ST_W-1:0] ST_MP        = 4'd6;
	localparam logic [ST_W-1:0] ST_MD        = 4'd7;
	localparam logic [ST_W-1:0] ST_MIL       = 4'd8;
	localparam logic [ST_W-1:0] ST_MIH       = 4'd9;
	localparam logic [ST_W-1:0] ST_SCALE     = 4'd10;
	localparam logic [ST_W-1:0] ST_DUTY      = 4'd11;

	// Configuration registers
	logic [msp_pkg::SPEED_W-1:0] target_q;
	logic [msp_pkg::GAIN_W-1:0]  gp_q;
	logic [msp_pkg::GAIN_W-1:0]  gi_q;
	logic [msp_pkg::GAIN_W-1:0]  gd_q;
	logic                        run_q;
	logic [msp_pkg::DIR_W-1:0]   dir_q;
	logic                        cfg_wr;
	logic [msp_pkg::REG_IDX_W-1:0] cfg_idx;

	// Sequencer and controller state
	logic [ST_W-1:0]                   state_q;
	logic [msp_pkg::SPEED_W-1:0]       fs_q;
	logic signed [msp_pkg::SUM_W-1:0]  sum_q;
	logic signed [msp_pkg::ERR_W-1:0]  prior_q;
	logic signed [msp_pkg::DIFF_W-1:0] diff_q;
	logic [msp_pkg::GP20_W-1:0]        gp20_q;
	logic [msp_pkg::GD400_W-1:0]       gd400_q;
	logic                              neg_q;
	logic                              sat_q;

	// Output register
	logic                        out_valid_q;
	logic [msp_pkg::DUTY_W-1:0]  duty_q;
	logic [msp_pkg::DIR_W-1:0]   mode_q;
	logic [msp_pkg::SPEED_W-1:0] speed_q;

	// Datapath
	msp_pkg::mac_ctl_t                 mac_ctl;
	msp_pkg::mul_op_t                  op_a;
	msp_pkg::mul_op_t                  op_b;
	logic signed [msp_pkg::ACC_W-1:0]  acc;
	logic                              accept;
	logic                              out_free;
	logic [msp_pkg::SPEED_Q_W-1:0]     speed_quo;
	logic signed [msp_pkg::ERR_W-1:0]  err;
	logic signed [msp_pkg::SUM_W:0]    sum_wide;
	logic signed [msp_pkg::SUM_W-1:0]  sum_sat;
	logic signed [msp_pkg::DIFF_W-1:0] diff;
	logic [msp_pkg::DUTY_W-1:0]        quo5;
	logic [msp_pkg::DUTY_W-1:0]        duty_next;

	assign accept   = tick.valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || drive.ready;

	// Register writes
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[msp_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			gp_q     <= 16'd256;
			gi_q     <= 16'd128;
			gd_q     <= 16'd26;
			run_q    <= 1'b0;
			dir_q    <= msp_pkg::DIR_OFF;
		end else if (cfg_wr) begin
			case (cfg_idx)
				msp_pkg::REG_TARGET: target_q <= pwdata[msp_pkg::SPEED_W-1:0];
				msp_pkg::REG_GAIN_P: gp_q     <= pwdata[msp_pkg::GAIN_W-1:0];
				msp_pkg::REG_GAIN_I: gi_q     <= pwdata[msp_pkg::GAIN_W-1:0];
				msp_pkg::REG_GAIN_D: gd_q     <= pwdata[msp_pkg::GAIN_W-1:0];
				msp_pkg::REG_RUN:    run_q    <= pwdata[0];
				msp_pkg::REG_DIR:    dir_q    <= pwdata[msp_pkg::DIR_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (cfg_idx)
			msp_pkg::REG_TARGET: prdata = msp_pkg::DATA_W'(target_q);
			msp_pkg::REG_GAIN_P: prdata = msp_pkg::DATA_W'(gp_q);
			msp_pkg::REG_GAIN_I: prdata = msp_pkg::DATA_W'(gi_q);
			msp_pkg::REG_GAIN_D: prdata = msp_pkg::DATA_W'(gd_q);
			msp_pkg::REG_RUN:    prdata = msp_pkg::DATA_W'(run_q);
			msp_pkg::REG_DIR:    prdata = msp_pkg::DATA_W'(dir_q);
			default:             prdata = '0;
		endcase
	end

	// Pick multiplier operands for each step
	always_comb begin
		mac_ctl = '0;
		op_a    = '0;
		op_b    = '0;
		case (state_q)
			ST_IDLE: begin
				mac_ctl.en  = accept;
				mac_ctl.rnd = 1'b1;
				op_a = msp_pkg::MUL_W'(tick.pulse_count);
				op_b = msp_pkg::FILT_PULSE_K;
			end
			ST_FILT_KEEP: begin
				mac_ctl.en   = 1'b1;
				mac_ctl.keep = 1'b1;
				op_a = msp_pkg::MUL_W'(fs_q);
				op_b = msp_pkg::FILT_KEEP_K;
			end
			ST_RECIP: begin
				mac_ctl.en = 1'b1;
				op_a = msp_pkg::MUL_W'(acc[msp_pkg::NUM_W-1:msp_pkg::FILT_PRE_SHIFT]);
				op_b = msp_pkg::RECIP_55;
			end
			ST_ERR: begin
				mac_ctl.en = 1'b1;
				op_a = msp_pkg::MUL_W'(gp_q);
				op_b = msp_pkg::P_SCALE;
			end
			ST_GD: begin
				mac_ctl.en = 1'b1;
				op_a = msp_pkg::MUL_W'(gd_q);
				op_b = msp_pkg::D_SCALE;
			end
			ST_MP: begin
				mac_ctl.en = 1'b1;
				op_a = msp_pkg::MUL_W'(prior_q);
				op_b = msp_pkg::MUL_W'(gp20_q);
			end
			ST_MD: begin
				mac_ctl.en   = 1'b1;
				mac_ctl.keep = 1'b1;
				op_a = msp_pkg::MUL_W'(diff_q);
				op_b = msp_pkg::MUL_W'(gd400_q);
			end
			ST_MIL: begin
				mac_ctl.en   = 1'b1;
				mac_ctl.keep = 1'b1;
				op_a = msp_pkg::MUL_W'(sum_q[msp_pkg::SUM_SPLIT-1:0]);
				op_b = msp_pkg::MUL_W'(gi_q);
			end
			ST_MIH: begin
				mac_ctl.en   = 1'b1;
				mac_ctl.keep = 1'b1;
				mac_ctl.shl  = 1'b1;
				// upper half carries the sign of the integral
				op_a = msp_pkg::MUL_W'($signed(sum_q[msp_pkg::SUM_W-1:msp_pkg::SUM_SPLIT]));
				op_b = msp_pkg::MUL_W'(gi_q);
			end
			ST_SCALE: begin
				mac_ctl.en = 1'b1;
				op_a = msp_pkg::MUL_W'(acc[msp_pkg::DUTY_SHIFT+msp_pkg::X_W-1:msp_pkg::DUTY_SHIFT]);
				op_b = msp_pkg::DIV5_RECIP;
			end
			default: ;
		endcase
	end

	msp_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	// Speed quotient, error, saturated integral, error difference and next duty
	always_comb begin
		speed_quo = acc[msp_pkg::RECIP_SHIFT+msp_pkg::SPEED_Q_W-1:msp_pkg::RECIP_SHIFT];
		err = $signed({1'b0, target_q}) - $signed({1'b0, fs_q});
		sum_wide = (msp_pkg::SUM_W+1)'(sum_q) + (msp_pkg::SUM_W+1)'(err);
		if (sum_wide[msp_pkg::SUM_W] != sum_wide[msp_pkg::SUM_W-1]) begin
			sum_sat = sum_wide[msp_pkg::SUM_W] ?
				{1'b1, {(msp_pkg::SUM_W-1){1'b0}}} : {1'b0, {(msp_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[msp_pkg::SUM_W-1:0];
		end
		diff = msp_pkg::DIFF_W'(err) - msp_pkg::DIFF_W'(prior_q);
		quo5 = acc[msp_pkg::DIV5_SHIFT+msp_pkg::DUTY_W-1:msp_pkg::DIV5_SHIFT];
		if (!run_q || neg_q) begin
			duty_next = '0;
		end else if (sat_q) begin
			duty_next = '1;
		end else begin
			duty_next = quo5;
		end
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:      if (accept) state_q <= ST_FILT_KEEP;
				ST_FILT_KEEP: state_q <= ST_RECIP;
				ST_RECIP:     state_q <= ST_SPEED;
				ST_SPEED:     state_q <= ST_ERR;
				ST_ERR:       state_q <= ST_GD;
				ST_GD:        state_q <= ST_MP;
				ST_MP:        state_q <= ST_MD;
				ST_MD:        state_q <= ST_MIL;
				ST_MIL:       state_q <= ST_MIH;
				ST_MIH:       state_q <= ST_SCALE;
				ST_SCALE:     state_q <= ST_DUTY;
				ST_DUTY:      if (out_free) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	// Update filter and PID state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= '0;
			sum_q   <= '0;
			prior_q <= '0;
		end else begin
			if (state_q == ST_SPEED) begin
				fs_q <= (|speed_quo[msp_pkg::SPEED_Q_W-1:msp_pkg::SPEED_W]) ?
					'1 : speed_quo[msp_pkg::SPEED_W-1:0];
			end
			if (state_q == ST_ERR) begin
				sum_q   <= sum_sat;
				prior_q <= err;
			end
		end
	end

	// Capture scaled gains, error difference and duty flags
	always_ff @(posedge clk) begin
		if (state_q == ST_ERR) begin
			diff_q <= diff;
		end
		if (state_q == ST_GD) begin
			gp20_q <= acc[msp_pkg::GP20_W-1:0];
		end
		if (state_q == ST_MP) begin
			gd400_q <= acc[msp_pkg::GD400_W-1:0];
		end
		if (state_q == ST_SCALE) begin
			neg_q <= acc[msp_pkg::ACC_W-1] || (acc == '0);
			sat_q <= acc >= msp_pkg::DUTY_SAT_LEVEL;
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DUTY) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (drive.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DUTY) && out_free) begin
			duty_q  <= duty_next;
			mode_q  <= (dir_q == msp_pkg::DIR_BAD) ? msp_pkg::DIR_OFF : dir_q;
			speed_q <= fs_q;
		end
	end

	assign tick.ready           = (state_q == ST_IDLE);
	assign drive.valid          = out_valid_q;
	assign drive.pwm_duty       = duty_q;
	assign drive.bridge_mode    = mode_q;
	assign drive.speed_estimate = speed_q;

	// Checks
	`MSP_ASSERT_IMP(a_duty_needs_run, clk, arst_n, drive.valid && (drive.pwm_duty != '0), run_q)
	`MSP_ASSERT_IMP(a_valid_from_seq, clk, arst_n, $rose(drive.valid), $past(state_q) == ST_DUTY)
	`MSP_ASSERT_NXT(a_accept_starts, clk, arst_n, tick.valid && tick.ready, state_q == ST_FILT_KEEP)
	`MSP_ASSERT_IMP(a_mode_legal, clk, arst_n, drive.valid, drive.bridge_mode != msp_pkg::DIR_BAD)

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the motor speed controller: register setup over APB, tick requests, PID drive check.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import msp_pkg::*;

	// Register slots past the end of the map; writes there must be dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// Filter and PID arithmetic
	localparam longint FILT_PULSE  = 64000;
	localparam longint FILT_KEEP   = 396;
	localparam longint FILT_BIAS   = 220;
	localparam longint FILT_DIV    = 440;
	localparam longint SPEED_TOP   = (64'sd1 <<< SPEED_W) - 1;
	localparam longint SUM_TOP     = (64'sd1 <<< (SUM_W - 1)) - 1;
	localparam longint SUM_BOTTOM  = -(64'sd1 <<< (SUM_W - 1));
	localparam longint P_WEIGHT    = 20;
	localparam longint D_WEIGHT    = 400;
	localparam longint DUTY_STEP   = 1310720;
	localparam longint DUTY_TOP    = 255;
	localparam int     COUNT_MAX   = (1 << COUNT_BITS) - 1;
	// Steady-state filtered speed per pulse of one tick, Q16.8 rpm
	localparam int     RPM_PER_PULSE = 1455;

	// Run shape
	localparam int IDLE_PCT      = 36;
	localparam int RANDOM_ITEMS  = 1780;
	localparam int WINDUP_ITEMS  = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PRINT_CAP     = 100;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic [DIR_W-1:0]   bridge;
		logic [SPEED_W-1:0] speed;
	} drive_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e             kind;
		logic [REG_IDX_W-1:0]  reg_idx;
		logic [DATA_W-1:0]     wdata;
		logic [COUNT_BITS-1:0] pulses;
		logic                  known;
		drive_t                want;
	} step_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	msp_tick_if  tick_ch ();
	msp_drive_if drive_ch ();

	motor_speed_pid_with_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tick    (tick_ch),
		.drive   (drive_ch)
	);

	// Shadow registers
	logic [SPEED_W-1:0] cfg_target;
	logic [GAIN_W-1:0]  cfg_kp;
	logic [GAIN_W-1:0]  cfg_ki;
	logic [GAIN_W-1:0]  cfg_kd;
	logic               cfg_run;
	logic [DIR_W-1:0]   cfg_dir;

	// Controller state mirror
	logic [SPEED_W-1:0]      filt_speed;
	logic signed [SUM_W-1:0] err_sum;
	logic signed [ERR_W-1:0] prior_err;

	drive_t    drive_due[$];
	step_row_t script[$];
	int        mismatches;
	int        src_gap;
	int        snk_gap;
	bit        hold_request;
	bit        bus_held;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Filter the tick, run the PID and advance the mirrored state
	function automatic drive_t next_drive(input logic [COUNT_BITS-1:0] pulses);
		longint num, spd, err, acc, n, q;
		drive_t r;
		num = longint'(pulses) * FILT_PULSE + FILT_KEEP * longint'(filt_speed) + FILT_BIAS;
		spd = num / FILT_DIV;
		if (spd > SPEED_TOP)
			spd = SPEED_TOP;
		err = longint'(cfg_target) - spd;
		acc = longint'(err_sum) + err;
		if (acc > SUM_TOP)
			acc = SUM_TOP;
		else if (acc < SUM_BOTTOM)
			acc = SUM_BOTTOM;
		n = P_WEIGHT * longint'(cfg_kp) * err + longint'(cfg_ki) * acc
			+ D_WEIGHT * longint'(cfg_kd) * (err - longint'(prior_err));
		r.duty = '0;
		if (n > 0) begin
			q = n / DUTY_STEP;
			r.duty = (q > DUTY_TOP) ? DUTY_W'(DUTY_TOP) : DUTY_W'(q);
		end
		if (!cfg_run)
			r.duty = '0;
		r.bridge = (cfg_dir == DIR_BAD) ? DIR_OFF : cfg_dir;
		r.speed = SPEED_W'(spd);
		filt_speed = SPEED_W'(spd);
		err_sum = SUM_W'(acc);
		prior_err = ERR_W'(err);
		return r;
	endfunction

	function automatic step_row_t tick_row(input logic [COUNT_BITS-1:0] pulses);
		step_row_t r;
		r = '0;
		r.kind = ROW_TICK;
		r.pulses = pulses;
		return r;
	endfunction

	function automatic step_row_t known_row(input logic [COUNT_BITS-1:0] pulses,
		input logic [DUTY_W-1:0] duty, input logic [DIR_W-1:0] bridge,
		input logic [SPEED_W-1:0] speed);
		step_row_t r;
		r = tick_row(pulses);
		r.known = 1'b1;
		r.want = '{duty, bridge, speed};
		return r;
	endfunction

	function automatic step_row_t write_row(input logic [REG_IDX_W-1:0] idx,
		input logic [DATA_W-1:0] val);
		step_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.wdata = val;
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(1, 1023));
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	function automatic logic [SPEED_W-1:0] pick_target();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return SPEED_W'($urandom());
		endcase
	endfunction

	// APB write: setup then access; keep psel up so writes can run back to back
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		bus_held = 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TARGET: cfg_target = val[SPEED_W-1:0];
			REG_GAIN_P: cfg_kp = val[GAIN_W-1:0];
			REG_GAIN_I: cfg_ki = val[GAIN_W-1:0];
			REG_GAIN_D: cfg_kd = val[GAIN_W-1:0];
			REG_RUN:    cfg_run = val[0];
			REG_DIR:    cfg_dir = val[DIR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic bus_release();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bus_held = 1'b0;
	endtask

	// Drop the tick request and wait until every result is back
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
	endtask

	// Offer one tick request, idling at random first; predict on acceptance
	task automatic offer_tick(input logic [COUNT_BITS-1:0] pulses, input bit known,
		input drive_t want);
		drive_t predicted;
		while (src_gap != 0 && $urandom_range(99) < src_gap) begin
			tick_ch.valid <= 1'b0;
			tick_ch.pulse_count <= COUNT_BITS'($urandom());
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.pulse_count <= pulses;
		do @(posedge clk); while (!tick_ch.ready);
		predicted = next_drive(pulses);
		drive_due.push_back(known ? want : predicted);
	endtask

	task automatic report_mismatch(input string field, input logic [SPEED_W-1:0] want,
		input logic [SPEED_W-1:0] got);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
	endtask

	task automatic check_drive();
		drive_t want;
		if (drive_due.size() == 0) begin
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t unrequested drive result: duty %0d mode %0d speed %0d", $time,
					drive_ch.pwm_duty, drive_ch.bridge_mode, drive_ch.speed_estimate);
			return;
		end
		want = drive_due.pop_front();
		if (drive_ch.pwm_duty !== want.duty)
			report_mismatch("pwm_duty", SPEED_W'(want.duty), SPEED_W'(drive_ch.pwm_duty));
		if (drive_ch.bridge_mode !== want.bridge)
			report_mismatch("bridge_mode", SPEED_W'(want.bridge), SPEED_W'(drive_ch.bridge_mode));
		if (drive_ch.speed_estimate !== want.speed)
			report_mismatch("speed_estimate", want.speed, drive_ch.speed_estimate);
	endtask

	// Result side: check at each accepted result, stall at random or hold off on request
	initial begin : drive_sink
		int hold_left;
		hold_left = 0;
		drive_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && drive_ch.valid && drive_ch.ready)
				check_drive();
			if (hold_left > 0) begin
				hold_left--;
				drive_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				drive_ch.ready <= 1'b0;
			end else begin
				drive_ch.ready <= !(snk_gap != 0 && $urandom_range(99) < snk_gap);
			end
		end
	end

	// Abort when nothing moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((tick_ch.valid && tick_ch.ready) || (drive_ch.valid && drive_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t no request or result accepted for %0d cycles", $time, STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int  total;
		int  phase;
		int  count;
		int  nominal;
		int  p;
		bit  plant;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.pulse_count <= '0;
		mismatches = 0;
		src_gap = IDLE_PCT;
		snk_gap = IDLE_PCT;
		hold_request = 1'b0;
		bus_held = 1'b0;
		cfg_target = '0;
		cfg_kp = GAIN_W'(256);
		cfg_ki = GAIN_W'(128);
		cfg_kd = GAIN_W'(26);
		cfg_run = 1'b0;
		cfg_dir = DIR_OFF;
		filt_speed = '0;
		err_sum = '0;
		prior_err = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		script = '{
			// out of reset: target zero, default gains, drive disabled
			known_row(12'd0, 8'd0, DIR_OFF, 24'd0),
			known_row(12'hFFF, 8'd0, DIR_OFF, 24'd595636),
			// full-scale target, every gain at maximum: drive pins at the top
			write_row(REG_RUN, 32'd1),
			write_row(REG_DIR, 32'(DIR_CW)),
			write_row(REG_TARGET, 32'h00FF_FFFF),
			write_row(REG_GAIN_P, 32'hFFFF_FFFF),
			write_row(REG_GAIN_I, 32'h0000_FFFF),
			write_row(REG_GAIN_D, 32'h0000_FFFF),
			known_row(12'd0, 8'd255, DIR_CW, 24'd536072),
			tick_row(12'hFFF),
			// zero target: error swings negative, drive goes below zero
			write_row(REG_TARGET, 32'd0),
			tick_row(12'h800),
			tick_row(12'hFFF),
			// proportional only, counterclockwise, target 200 rpm
			write_row(REG_DIR, 32'(DIR_CCW)),
			write_row(REG_TARGET, 32'h0000_C800),
			write_row(REG_GAIN_P, 32'h0000_0100),
			write_row(REG_GAIN_I, 32'd0),
			write_row(REG_GAIN_D, 32'd0),
			tick_row(12'd0),
			tick_row(12'd55),
			tick_row(12'h555),
			tick_row(12'hAAA),
			tick_row(12'd1),
			// unused direction code is sent out as the off bridge mode
			write_row(REG_DIR, 32'(DIR_BAD)),
			tick_row(12'd140),
			// writes past the map are dropped; upper data bits are ignored
			write_row(REG_SPARE_A, 32'hFFFF_FFFF),
			write_row(REG_SPARE_B, 32'hFFFF_FFFF),
			write_row(REG_RUN, 32'hFFFF_FFFE),
			write_row(REG_DIR, 32'hFFFF_FFFE),
			tick_row(12'd200),
			tick_row(12'hFFF)
		};

		// Walk the directed table
		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				settle();
				reg_write(script[i].reg_idx, script[i].wdata);
			end else begin
				if (bus_held)
					bus_release();
				offer_tick(script[i].pulses, script[i].known, script[i].want);
			end
		end

		// Random phases: mostly closed-loop-like pulse counts around the target
		total = 0;
		phase = 0;
		while (total < RANDOM_ITEMS) begin
			plant = $urandom_range(9) < 7;
			nominal = $urandom_range(COUNT_MAX);
			settle();
			if (plant) begin
				reg_write(REG_TARGET, DATA_W'(nominal * RPM_PER_PULSE));
				reg_write(REG_GAIN_P, DATA_W'($urandom_range(1023)));
				reg_write(REG_GAIN_I, DATA_W'($urandom_range(63)));
				reg_write(REG_GAIN_D, DATA_W'($urandom_range(255)));
			end else begin
				reg_write(REG_TARGET, {8'($urandom()), pick_target()});
				reg_write(REG_GAIN_P, DATA_W'(pick_gain()));
				reg_write(REG_GAIN_I, DATA_W'(pick_gain()));
				reg_write(REG_GAIN_D, DATA_W'(pick_gain()));
			end
			reg_write(REG_RUN, DATA_W'($urandom_range(3) != 0));
			reg_write(REG_DIR, DATA_W'($urandom_range(3)));
			if ($urandom_range(3) == 0)
				reg_write(($urandom_range(1) != 0) ? REG_SPARE_B : REG_SPARE_A, $urandom());
			bus_release();

			// one phase runs flat out; another holds the result side off
			src_gap = (phase == 2) ? 0 : IDLE_PCT;
			snk_gap = (phase == 2) ? 0 : IDLE_PCT;
			if (phase == 4)
				hold_request = 1'b1;

			count = $urandom_range(60, 140);
			repeat (count) begin
				if (plant && $urandom_range(9) != 0) begin
					p = nominal + int'($urandom_range(24)) - 12;
					if (p < 0)
						p = 0;
					if (p > COUNT_MAX)
						p = COUNT_MAX;
				end else begin
					p = $urandom_range(COUNT_MAX);
				end
				offer_tick(COUNT_BITS'(p), 1'b0, '0);
			end
			total += count;
			phase++;
		end

		// Integral windup: full target, motor stalled, the sum climbs every tick
		settle();
		src_gap = 0;
		snk_gap = 0;
		reg_write(REG_TARGET, 32'h00FF_FFFF);
		reg_write(REG_GAIN_P, DATA_W'($urandom_range(65535)));
		reg_write(REG_GAIN_I, 32'h0000_FFFF);
		reg_write(REG_GAIN_D, DATA_W'($urandom_range(65535)));
		reg_write(REG_RUN, 32'd1);
		reg_write(REG_DIR, 32'(DIR_CW));
		bus_release();
		repeat (WINDUP_ITEMS)
			offer_tick(COUNT_BITS'($urandom_range(3)), 1'b0, '0);

		// Drain and report
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/msp_pkg.sv
rtl/msp_tick_if.sv
rtl/msp_drive_if.sv
rtl/msp_mac.sv
rtl/motor_speed_pid_with_filter.sv
bench/tb_top.sv
